// ===== rtl/pph_pkg.sv =====
`default_nettype none

package pph_pkg;

  // item kind codes
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // vertex_count after reset
  localparam logic [4:0] VCOUNT_RESET = 5'd4;

  // fixed field widths
  localparam int SLOT_W   = 4;
  localparam int FIELD_W  = 16;
  localparam int RADIUS_W = 15;

  typedef struct packed {
    logic                      kind;
    logic [SLOT_W-1:0]         vertex_slot;
    logic signed [FIELD_W-1:0] vertex_x;
    logic signed [FIELD_W-1:0] vertex_y;
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
    logic [RADIUS_W-1:0]       pick_radius;
  } in_word_t;

  typedef struct packed {
    logic              inside_res;
    logic              vertex_hit;
    logic [SLOT_W-1:0] hit_index;
  } out_word_t;

  typedef struct packed {
    logic [4:0] vertex_count;
  } cfg_word_t;

  // one scan step handed to the evaluator
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              tri_en;
    logic              dist_en;
    logic [SLOT_W-1:0] idx;
  } step_t;

  // evaluator verdict for one step
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              tri_hit;
    logic              dist_hit;
    logic [SLOT_W-1:0] idx;
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/pph_chan.sv =====
`default_nettype none

interface pph_chan #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pph_cell.sv =====
`default_nettype none

// One vertex of the rotating corner ring.
module pph_cell #(
  parameter int CW = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 load_en_i,
  input  wire logic signed [CW-1:0] load_x_i,
  input  wire logic signed [CW-1:0] load_y_i,
  input  wire logic                 shift_en_i,
  input  wire logic signed [CW-1:0] nbr_x_i,
  input  wire logic signed [CW-1:0] nbr_y_i,
  output logic signed [CW-1:0]      x_o,
  output logic signed [CW-1:0]      y_o
);

  logic signed [CW-1:0] x_q, y_q;

  // load has priority; shift only happens during a scan
  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      x_q <= load_x_i;
      y_q <= load_y_i;
    end else if (shift_en_i) begin
      x_q <= nbr_x_i;
      y_q <= nbr_y_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

`default_nettype wire

// ===== rtl/pph_eval.sv =====
`default_nettype none

// Three-stage geometry unit: differences, products, signs and compare.
module pph_eval #(
  parameter int CW = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pph_pkg::step_t       step_i,
  input  wire logic signed [CW-1:0] v0x_i,
  input  wire logic signed [CW-1:0] v0y_i,
  input  wire logic signed [CW-1:0] vjx_i,
  input  wire logic signed [CW-1:0] vjy_i,
  input  wire logic signed [CW-1:0] vkx_i,
  input  wire logic signed [CW-1:0] vky_i,
  input  wire logic signed [CW-1:0] px_i,
  input  wire logic signed [CW-1:0] py_i,
  input  wire logic [pph_pkg::RADIUS_W-1:0] radius_i,
  output pph_pkg::verdict_t         verdict_o
);

  localparam int DW  = CW + 1;
  localparam int PW  = 2 * CW + 2;
  localparam int RW  = 2 * pph_pkg::RADIUS_W;
  localparam int SQW = (PW + 1 > RW + 1) ? PW + 1 : RW + 1;

  pph_pkg::step_t s1_q, s2_q;
  pph_pkg::verdict_t s3_q;

  // stage 1: edge vectors and vertex-minus-point offsets
  logic signed [DW-1:0] e1x_q, e1y_q, d1x_q, d1y_q;
  logic signed [DW-1:0] e2x_q, e2y_q, d2x_q, d2y_q;
  logic signed [DW-1:0] e3x_q, e3y_q, d3x_q, d3y_q;
  logic [pph_pkg::RADIUS_W-1:0] r_q;

  always_ff @(posedge clk_i) begin
    e1x_q <= DW'(vjx_i) - DW'(v0x_i);
    e1y_q <= DW'(vjy_i) - DW'(v0y_i);
    d1x_q <= DW'(v0x_i) - DW'(px_i);
    d1y_q <= DW'(v0y_i) - DW'(py_i);
    e2x_q <= DW'(vkx_i) - DW'(vjx_i);
    e2y_q <= DW'(vky_i) - DW'(vjy_i);
    d2x_q <= DW'(vjx_i) - DW'(px_i);
    d2y_q <= DW'(vjy_i) - DW'(py_i);
    e3x_q <= DW'(v0x_i) - DW'(vkx_i);
    e3y_q <= DW'(v0y_i) - DW'(vky_i);
    d3x_q <= DW'(vkx_i) - DW'(px_i);
    d3y_q <= DW'(vky_i) - DW'(py_i);
    r_q   <= radius_i;
  end

  // stage 2: cross product halves and squared distances
  logic signed [PW-1:0] a1_q, b1_q, a2_q, b2_q, a3_q, b3_q, sqx_q, sqy_q;
  logic [RW-1:0]        r2_q;

  always_ff @(posedge clk_i) begin
    a1_q  <= e1x_q * d1y_q;
    b1_q  <= e1y_q * d1x_q;
    a2_q  <= e2x_q * d2y_q;
    b2_q  <= e2y_q * d2x_q;
    a3_q  <= e3x_q * d3y_q;
    b3_q  <= e3y_q * d3x_q;
    sqx_q <= d3x_q * d3x_q;
    sqy_q <= d3y_q * d3y_q;
    r2_q  <= r_q * r_q;
  end

  // stage 3: signs of the cross products, distance against radius
  logic signed [PW:0] c1, c2, c3;
  logic [SQW-1:0]     dist2, lim2;
  logic               tri_hit, dist_hit;

  always_comb begin
    c1       = (PW+1)'(a1_q) - (PW+1)'(b1_q);
    c2       = (PW+1)'(a2_q) - (PW+1)'(b2_q);
    c3       = (PW+1)'(a3_q) - (PW+1)'(b3_q);
    dist2    = SQW'($unsigned(sqx_q)) + SQW'($unsigned(sqy_q));
    lim2     = SQW'(r2_q);
    tri_hit  = c1[PW] & c2[PW] & c3[PW];
    dist_hit = (dist2 <= lim2);
  end

  // step control follows the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else begin
      s1_q           <= step_i;
      s2_q           <= s1_q;
      s3_q.valid     <= s2_q.valid;
      s3_q.last      <= s2_q.valid & s2_q.last;
      s3_q.tri_hit   <= s2_q.valid & s2_q.tri_en & tri_hit;
      s3_q.dist_hit  <= s2_q.valid & s2_q.dist_en & dist_hit;
      s3_q.idx       <= s2_q.idx;
    end
  end

  assign verdict_o = s3_q;

endmodule

`default_nettype wire

// ===== rtl/polygon_point_hit_test.sv =====
// Load word: written to its corner slot on accept; ST_DONE then stages a result.
// Query word: ST_SCAN walks MAX_VERTICES steps, ST_DRAIN waits for the last
// verdict, then ST_DONE stages the result. A new word is taken only in ST_IDLE.
// In a scan the corner ring rotates one place per cycle; one fan triangle and one
// vertex go through the 3-stage geometry unit per cycle. Reset (rst_ni low, async)
// clears control state, sets vertex_count to 4; corners stay undefined until loaded.
`default_nettype none

module polygon_point_hit_test #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pph_chan.sink     in_i,
  pph_chan.sink     cfg_i,
  pph_chan.source   out_o
);

  localparam int CW = COORD_BITS;
  localparam int M  = MAX_VERTICES;
  localparam int SW = $clog2(M);
  localparam int NW = ($clog2(M + 1) > 5) ? $clog2(M + 1) : 5;

  pph_pkg::state_e state_q, state_d;

  logic [4:0]    vcount_q;
  logic [NW-1:0] n_eff;
  logic [SW-1:0] step_q, step_d;

  logic signed [CW-1:0] cx [M];
  logic signed [CW-1:0] cy [M];
  logic signed [CW-1:0] prevx_q, prevy_q, v0x_q, v0y_q, px_q, py_q;
  logic [pph_pkg::RADIUS_W-1:0] r_q;

  logic in_fire, load_fire, query_fire, scanning, slot_free;
  pph_pkg::step_t    step_s;
  pph_pkg::verdict_t verdict;

  logic                      inside_q, inside_d, hit_q, hit_d;
  logic [pph_pkg::SLOT_W-1:0] idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  pph_pkg::out_word_t        out_q, out_d;

  // configuration: single register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= pph_pkg::VCOUNT_RESET;
    end else if (cfg_i.valid) begin
      vcount_q <= cfg_i.data.vertex_count;
    end
  end

  // counts above the ring size act as the ring size
  assign n_eff = (NW'(vcount_q) > NW'(M)) ? NW'(M) : NW'(vcount_q);

  // input handshake
  assign in_i.ready = (state_q == pph_pkg::ST_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign load_fire  = in_fire & (in_i.data.kind == pph_pkg::KIND_LOAD);
  assign query_fire = in_fire & (in_i.data.kind == pph_pkg::KIND_QUERY);
  assign scanning   = (state_q == pph_pkg::ST_SCAN);

  // corner ring: cell 0 is the head, each cell takes its upper neighbor
  for (genvar m = 0; m < M; m++) begin : g_ring
    localparam int NB = (m + 1) % M;
    logic load_en;
    assign load_en = load_fire & (int'(in_i.data.vertex_slot) == m);

    pph_cell #(.CW(CW)) u_cell (
      .clk_i      (clk_i),
      .load_en_i  (load_en),
      .load_x_i   (CW'(in_i.data.vertex_x)),
      .load_y_i   (CW'(in_i.data.vertex_y)),
      .shift_en_i (scanning),
      .nbr_x_i    (cx[NB]),
      .nbr_y_i    (cy[NB]),
      .x_o        (cx[m]),
      .y_o        (cy[m])
    );
  end

  // step issued this cycle: head holds vertex step_q
  always_comb begin
    step_s.valid   = scanning;
    step_s.last    = (step_q == SW'(M - 1));
    step_s.dist_en = (NW'(step_q) < n_eff);
    step_s.tri_en  = (step_q >= SW'(2)) & (NW'(step_q) < n_eff);
    step_s.idx     = pph_pkg::SLOT_W'(step_q);
  end

  pph_eval #(.CW(CW)) u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step_s),
    .v0x_i     (v0x_q),
    .v0y_i     (v0y_q),
    .vjx_i     (prevx_q),
    .vjy_i     (prevy_q),
    .vkx_i     (cx[0]),
    .vky_i     (cy[0]),
    .px_i      (px_q),
    .py_i      (py_q),
    .radius_i  (r_q),
    .verdict_o (verdict)
  );

  // query operands and window registers
  always_ff @(posedge clk_i) begin
    if (query_fire) begin
      px_q <= CW'(in_i.data.point_x);
      py_q <= CW'(in_i.data.point_y);
      r_q  <= in_i.data.pick_radius;
    end
    if (scanning) begin
      prevx_q <= cx[0];
      prevy_q <= cy[0];
      if (step_q == '0) begin
        v0x_q <= cx[0];
        v0y_q <= cy[0];
      end
    end
  end

  assign slot_free = ~out_valid_q | out_o.ready;

  // sequencer, verdict accumulation and output staging
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    inside_d    = inside_q;
    hit_d       = hit_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_d       = out_q;

    if (verdict.valid) begin
      inside_d = inside_q | verdict.tri_hit;
      if (verdict.dist_hit & ~hit_q) begin
        hit_d = 1'b1;
        idx_d = verdict.idx;
      end
    end

    unique case (state_q)
      pph_pkg::ST_IDLE: begin
        if (in_fire) begin
          inside_d = 1'b0;
          hit_d    = 1'b0;
          idx_d    = '0;
          step_d   = '0;
          state_d  = query_fire ? pph_pkg::ST_SCAN : pph_pkg::ST_DONE;
        end
      end
      pph_pkg::ST_SCAN: begin
        step_d = step_q + SW'(1);
        if (step_s.last) begin
          state_d = pph_pkg::ST_DRAIN;
        end
      end
      pph_pkg::ST_DRAIN: begin
        if (verdict.last) begin
          state_d = pph_pkg::ST_DONE;
        end
      end
      pph_pkg::ST_DONE: begin
        if (slot_free) begin
          out_valid_d      = 1'b1;
          out_d.inside_res = inside_q;
          out_d.vertex_hit = hit_q;
          out_d.hit_index  = idx_q;
          state_d          = pph_pkg::ST_IDLE;
        end
      end
      default: state_d = pph_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pph_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      inside_q    <= inside_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    out_q <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

// ===== verif/polygon_point_hit_test_tb.sv =====
`timescale 1ns / 1ps

module polygon_point_hit_test_tb;

  localparam int MAX_VERT   = 16;
  localparam int SETTLE_CYC = MAX_VERT + 8;
  localparam int STALL_MAX  = 4000;
  localparam int N_PHASES   = 10;
  localparam int PHASE_LEN  = 65;

  logic clk_i;
  logic rst_ni;

  pph_chan #(.payload_t(pph_pkg::in_word_t))  in_ch ();
  pph_chan #(.payload_t(pph_pkg::cfg_word_t)) cfg_ch ();
  pph_chan #(.payload_t(pph_pkg::out_word_t)) out_ch ();

  polygon_point_hit_test #(
    .MAX_VERTICES(MAX_VERT),
    .COORD_BITS  (16)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .cfg_i (cfg_ch),
    .out_o (out_ch)
  );

  // words waiting for the driver, verdicts waiting for the block
  pph_pkg::in_word_t  word_q[$];
  pph_pkg::out_word_t verdict_q[$];

  // predictor state
  logic signed [pph_pkg::FIELD_W-1:0] corner_x_r[MAX_VERT];
  logic signed [pph_pkg::FIELD_W-1:0] corner_y_r[MAX_VERT];
  logic [4:0]                         vert_count;

  int  err_cnt;
  int  quiet_cyc;
  bit  idle_on;
  int  in_gap;
  int  out_stall;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // edge cross product: (b - a) x (a - p)
  function automatic longint edge_cross(int a, int b, longint px, longint py);
    longint ax, ay, ex, ey;
    ax = corner_x_r[a];
    ay = corner_y_r[a];
    ex = longint'(corner_x_r[b]) - ax;
    ey = longint'(corner_y_r[b]) - ay;
    return ex * (ay - py) - ey * (ax - px);
  endfunction

  // works out the verdict for one word and applies loads to the corner store
  function automatic pph_pkg::out_word_t predict_hit(pph_pkg::in_word_t w);
    pph_pkg::out_word_t r;
    longint             px, py, r2, dx, dy;
    int                 n;
    bit                 in_tri;
    r = '0;
    if (w.kind == pph_pkg::KIND_LOAD) begin
      corner_x_r[w.vertex_slot] = w.vertex_x;
      corner_y_r[w.vertex_slot] = w.vertex_y;
      return r;
    end
    px = w.point_x;
    py = w.point_y;
    r2 = longint'(w.pick_radius) * longint'(w.pick_radius);
    n = (int'(vert_count) > MAX_VERT) ? MAX_VERT : int'(vert_count);
    in_tri = 1'b0;
    for (int i = 0; i + 2 < n; i++) begin
      if (!in_tri && edge_cross(0, i + 1, px, py) < 0 &&
          edge_cross(i + 1, i + 2, px, py) < 0 && edge_cross(i + 2, 0, px, py) < 0) begin
        in_tri = 1'b1;
      end
    end
    r.inside_res = in_tri;
    for (int i = 0; i < n; i++) begin
      dx = longint'(corner_x_r[i]) - px;
      dy = longint'(corner_y_r[i]) - py;
      if (!r.vertex_hit && dx * dx + dy * dy <= r2) begin
        r.vertex_hit = 1'b1;
        r.hit_index  = i[pph_pkg::SLOT_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic signed [pph_pkg::FIELD_W-1:0] clamp16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[pph_pkg::FIELD_W-1:0];
  endfunction

  function automatic pph_pkg::in_word_t rand_word();
    pph_pkg::in_word_t w;
    w.kind        = 1'($urandom);
    w.vertex_slot = 4'($urandom);
    w.vertex_x    = 16'($urandom);
    w.vertex_y    = 16'($urandom);
    w.point_x     = 16'($urandom);
    w.point_y     = 16'($urandom);
    w.pick_radius = 15'($urandom);
    return w;
  endfunction

  task automatic push_load(int slot, int x, int y);
    pph_pkg::in_word_t w;
    w             = rand_word();
    w.kind        = pph_pkg::KIND_LOAD;
    w.vertex_slot = slot[pph_pkg::SLOT_W-1:0];
    w.vertex_x    = clamp16(x);
    w.vertex_y    = clamp16(y);
    word_q        = {word_q, w};
  endtask

  task automatic push_query(int x, int y, int rad);
    pph_pkg::in_word_t w;
    w             = rand_word();
    w.kind        = pph_pkg::KIND_QUERY;
    w.point_x     = clamp16(x);
    w.point_y     = clamp16(y);
    w.pick_radius = rad[pph_pkg::RADIUS_W-1:0];
    word_q        = {word_q, w};
  endtask

  // wait until the block has nothing in flight, then let it drain
  task automatic settle();
    while (word_q.size() != 0 || in_ch.valid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_count(int vc);
    @(posedge clk_i);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.data.vertex_count <= vc[4:0];
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // one polygon placed on a circle, then mostly aimed queries with some noise
  task automatic queue_phase(int vc, int n_items);
    int  n, cx, cy, rad, dir, span, tmp, j, sel, pick, jit;
    real ang0, ang;
    int  vx[MAX_VERT];
    int  vy[MAX_VERT];
    int  order[MAX_VERT];
    n    = (vc > MAX_VERT) ? MAX_VERT : vc;
    rad  = $urandom_range(64, 16000);
    span = 32767 - rad;
    cx   = int'($urandom_range(0, 2 * span)) - span;
    cy   = int'($urandom_range(0, 2 * span)) - span;
    dir  = ($urandom_range(0, 3) == 0) ? -1 : 1;
    ang0 = $urandom_range(0, 359) * 3.14159265 / 180.0;
    for (int k = 0; k < n; k++) begin
      ang      = ang0 + dir * 2.0 * 3.14159265 * k / n;
      vx[k]    = cx + $rtoi(rad * $cos(ang));
      vy[k]    = cy + $rtoi(rad * $sin(ang));
      order[k] = k;
    end
    for (int k = n - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < n; k++) push_load(order[k], vx[order[k]], vy[order[k]]);

    for (int t = 0; t < n_items; t++) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        // stray load, sometimes moving a corner in use
        pick = $urandom_range(0, MAX_VERT - 1);
        if (pick < n) begin
          vx[pick] = int'($urandom_range(0, 65535)) - 32768;
          vy[pick] = int'($urandom_range(0, 65535)) - 32768;
          push_load(pick, vx[pick], vy[pick]);
        end else begin
          push_load(pick, int'($urandom_range(0, 65535)) - 32768,
                    int'($urandom_range(0, 65535)) - 32768);
        end
      end else if (sel < 45) begin
        push_query(cx + int'($urandom_range(0, 2 * rad)) - rad,
                   cy + int'($urandom_range(0, 2 * rad)) - rad, $urandom_range(0, rad));
      end else if (sel < 78 && n > 0) begin
        pick = $urandom_range(0, n - 1);
        jit  = $urandom_range(0, 64);
        push_query(vx[pick] + int'($urandom_range(0, 2 * jit)) - jit,
                   vy[pick] + int'($urandom_range(0, 2 * jit)) - jit, $urandom_range(0, 128));
      end else if (sel < 92) begin
        push_query(int'($urandom_range(0, 65535)) - 32768,
                   int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 32767));
      end else begin
        push_query(int'($urandom_range(0, 65535)) - 32768,
                   int'($urandom_range(0, 65535)) - 32768,
                   $urandom_range(0, 1) ? 32767 : 0);
      end
    end
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      in_gap      <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap      <= in_gap - 1;
      end else if (word_q.size() != 0) begin
        in_ch.data  <= word_q.pop_front();
        in_ch.valid <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) in_gap <= $urandom_range(1, 4);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall    <= out_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) out_stall <= $urandom_range(1, 4);
    end
  end

  // monitor: predict on accept, check on result, watchdog
  always @(posedge clk_i) begin
    pph_pkg::out_word_t exp_w;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) vert_count = cfg_ch.data.vertex_count;
      if (in_ch.valid && in_ch.ready) verdict_q = {verdict_q, predict_hit(in_ch.data)};
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result word: inside_res %0d vertex_hit %0d hit_index %0d",
                 out_ch.data.inside_res, out_ch.data.vertex_hit, out_ch.data.hit_index);
          err_cnt++;
        end else begin
          exp_w = verdict_q.pop_front();
          if (out_ch.data.inside_res !== exp_w.inside_res) begin
            $error("inside_res: expected %0d, actual %0d", exp_w.inside_res,
                   out_ch.data.inside_res);
            err_cnt++;
          end
          if (out_ch.data.vertex_hit !== exp_w.vertex_hit) begin
            $error("vertex_hit: expected %0d, actual %0d", exp_w.vertex_hit,
                   out_ch.data.vertex_hit);
            err_cnt++;
          end
          if (out_ch.data.hit_index !== exp_w.hit_index) begin
            $error("hit_index: expected %0d, actual %0d", exp_w.hit_index,
                   out_ch.data.hit_index);
            err_cnt++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cyc = 0;
      end else begin
        quiet_cyc++;
      end
      if (quiet_cyc >= STALL_MAX) begin
        $display("** polygon_point_hit_test: FAILED **");
        $finish;
      end
    end
  end

  // sequence of phases
  initial begin
    int counts[N_PHASES];
    counts     = '{3, 16, 7, 31, 0, 2, 12, 1, 17, 16};
    err_cnt    = 0;
    quiet_cyc  = 0;
    idle_on    = 1'b1;
    vert_count = pph_pkg::VCOUNT_RESET;
    rst_ni       <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale square, counterclockwise; corners, edges and radius boundaries
    set_count(4);
    push_load(0, -32768, -32768);
    push_load(1, 32767, -32768);
    push_load(2, 32767, 32767);
    push_load(3, -32768, 32767);
    push_query(0, 0, 0);
    push_query(-32768, -32768, 0);
    push_query(32767, 32767, 32767);
    push_query(0, -32768, 0);
    push_query(-32768, 0, 32767);
    push_query(32767, 0, 32767);
    push_load(15, 32767, -32768);
    settle();

    // no vertices in use: no triangle, no search
    set_count(0);
    push_query(0, 0, 32767);
    settle();

    // one and two vertices: search only
    set_count(1);
    push_query(-32768, -32768, 0);
    settle();
    set_count(2);
    push_query(32767, -32767, 1);
    settle();

    // clockwise triangle never counts as inside
    set_count(3);
    push_load(0, -1600, -1600);
    push_load(1, 0, 1600);
    push_load(2, 1600, -1600);
    push_query(0, 0, 16);
    push_query(0, 1600, 0);
    settle();

    // random phases
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == N_PHASES - 1) idle_on = 1'b0;
      set_count(counts[p]);
      if (p == 1) begin
        // sender holds back until every outstanding result is in
        queue_phase(counts[p], PHASE_LEN / 2);
        while (word_q.size() != 0 || in_ch.valid || verdict_q.size() != 0) @(posedge clk_i);
        queue_phase(counts[p], PHASE_LEN - PHASE_LEN / 2);
      end else begin
        queue_phase(counts[p], PHASE_LEN);
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("** polygon_point_hit_test: PASSED **");
    end else begin
      $display("** polygon_point_hit_test: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pph_pkg.sv
rtl/pph_chan.sv
rtl/pph_cell.sv
rtl/pph_eval.sv
rtl/polygon_point_hit_test.sv
verif/polygon_point_hit_test_tb.sv
